/* rtl/tct_pkg.sv */
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types, codes and helpers of the TCP connection tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tct_pkg;

    localparam int unsigned FLAG_SYN = 0;
    localparam int unsigned FLAG_ACK = 1;
    localparam int unsigned FLAG_FIN = 2;
    localparam int unsigned FLAG_RST = 3;

    localparam logic OP_PACKET  = 1'b0;
    localparam logic OP_REFRESH = 1'b1;

    typedef enum logic [2:0] {
        ST_EMPTY       = 3'd0,
        ST_WAIT_SYNACK = 3'd1,
        ST_WAIT_ACK    = 3'd2,
        ST_UP          = 3'd3,
        ST_FIN_WAIT    = 3'd4,
        ST_CLOSED      = 3'd5,
        ST_RESET       = 3'd6
    } lifecycle_t;

    typedef struct packed {
        logic        opcode;
        logic [31:0] now_seconds;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [3:0]  tcp_flags;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [15:0] ip_payload_len;
        logic [5:0]  tcp_header_len;
        logic [15:0] total_len;
    } hdr_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  conn_state;
        logic [31:0] packet_total;
        logic [31:0] cur_packets;
        logic [31:0] cur_payload_bytes;
        logic [31:0] cur_all_bytes;
        logic [31:0] prev_packets;
        logic [31:0] prev_payload_bytes;
        logic [31:0] prev_all_bytes;
        logic [63:0] payload_grand_total;
        logic [31:0] last_seen_seconds;
    } res_t;

    typedef struct packed {
        lifecycle_t  lifecycle;
        logic [31:0] tuple_src_addr;
        logic [31:0] tuple_dst_addr;
        logic [15:0] tuple_src_port;
        logic [15:0] tuple_dst_port;
        logic [31:0] packets_seen;
        logic [31:0] period_second;
        logic [31:0] period_packets;
        logic [31:0] period_payload;
        logic [31:0] period_bytes;
        logic [31:0] earlier_packets;
        logic [31:0] earlier_payload;
        logic [31:0] earlier_bytes;
        logic [63:0] payload_sum;
        logic [31:0] last_seen;
        logic [31:0] expect_ack_src;
        logic [31:0] expect_ack_dst;
        logic        fin_acked_src;
        logic        fin_acked_dst;
    } conn_t;

    function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

    function automatic logic [63:0] sat_add64(logic [63:0] a, logic [15:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {49'd0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/tct_hdr_if.sv */
// ----------------------------------------------------------------------------
// tct_hdr_if
// Valid/ready channel carrying one parsed packet header per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tct_hdr_if;
    logic          valid;
    logic          ready;
    tct_pkg::hdr_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/tct_res_if.sv */
// ----------------------------------------------------------------------------
// tct_res_if
// Valid/ready channel carrying one tracker result per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tct_res_if;
    logic          valid;
    logic          ready;
    tct_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/tct_hdr_stage.sv */
// ----------------------------------------------------------------------------
// tct_hdr_stage
// Input register: holds one header until the update stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_hdr_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    tct_hdr_if.sink            hdr,
    input  wire logic          advance,
    output logic               valid,
    output tct_pkg::hdr_t      item
);

    logic          valid_reg;
    logic          valid_next;
    tct_pkg::hdr_t item_reg;
    logic          xfer;

    assign hdr.ready = !valid_reg || advance;
    assign xfer      = hdr.valid && hdr.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (xfer)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            item_reg <= hdr.data;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

`default_nettype wire

/* rtl/tct_core.sv */
// ----------------------------------------------------------------------------
// tct_core
// Connection state and counters; computes the update and result of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire tct_pkg::hdr_t item,
    output tct_pkg::res_t      res
);

    tct_pkg::conn_t state_reg;
    tct_pkg::conn_t state_next;
    logic           acc;
    logic [15:0]    payload;
    logic           fwd;
    logic           rev;
    logic [31:0]    want;

    assign payload = (item.ip_payload_len > {10'd0, item.tcp_header_len})
                   ? item.ip_payload_len - {10'd0, item.tcp_header_len} : 16'd0;

    assign fwd = item.src_addr == state_reg.tuple_src_addr
              && item.dst_addr == state_reg.tuple_dst_addr
              && item.src_port == state_reg.tuple_src_port
              && item.dst_port == state_reg.tuple_dst_port;
    assign rev = item.dst_addr == state_reg.tuple_src_addr
              && item.src_addr == state_reg.tuple_dst_addr
              && item.dst_port == state_reg.tuple_src_port
              && item.src_port == state_reg.tuple_dst_port;

    assign want = item.seq_number + {16'd0, payload} + 32'd1;

    always_comb
    begin
        state_next = state_reg;
        acc        = 1'b0;
        if (item.opcode == tct_pkg::OP_REFRESH)
        begin
            if (state_reg.period_second != item.now_seconds)
            begin
                state_next.earlier_packets = state_reg.period_packets;
                state_next.earlier_payload = state_reg.period_payload;
                state_next.earlier_bytes   = state_reg.period_bytes;
                state_next.period_second   = item.now_seconds;
                state_next.period_packets  = '0;
                state_next.period_payload  = '0;
                state_next.period_bytes    = '0;
            end
        end
        else if (state_reg.lifecycle == tct_pkg::ST_EMPTY)
        begin
            acc                       = 1'b1;
            state_next.tuple_src_addr = item.src_addr;
            state_next.tuple_dst_addr = item.dst_addr;
            state_next.tuple_src_port = item.src_port;
            state_next.tuple_dst_port = item.dst_port;
            state_next.lifecycle      = item.tcp_flags[tct_pkg::FLAG_SYN]
                                      ? tct_pkg::ST_WAIT_SYNACK : tct_pkg::ST_UP;
            state_next.packets_seen   = 32'd1;
            state_next.period_second  = item.now_seconds;
            state_next.period_packets = 32'd1;
            state_next.period_payload = {16'd0, payload};
            state_next.period_bytes   = {16'd0, item.total_len};
            state_next.payload_sum    = {48'd0, payload};
            state_next.last_seen      = item.now_seconds;
            state_next.expect_ack_src = '0;
            state_next.expect_ack_dst = '0;
            state_next.fin_acked_src  = 1'b0;
            state_next.fin_acked_dst  = 1'b0;
        end
        else if (state_reg.lifecycle != tct_pkg::ST_CLOSED && (fwd || rev))
        begin
            acc                     = 1'b1;
            state_next.packets_seen = tct_pkg::sat_add32(state_reg.packets_seen, 32'd1);
            if (state_reg.period_second != item.now_seconds)
            begin
                state_next.earlier_packets = state_reg.period_packets;
                state_next.earlier_payload = state_reg.period_payload;
                state_next.earlier_bytes   = state_reg.period_bytes;
                state_next.period_second   = item.now_seconds;
                state_next.period_packets  = '0;
                state_next.period_payload  = '0;
                state_next.period_bytes    = '0;
            end
            state_next.period_packets = tct_pkg::sat_add32(state_next.period_packets, 32'd1);
            state_next.period_payload = tct_pkg::sat_add32(state_next.period_payload,
                                                           {16'd0, payload});
            state_next.period_bytes   = tct_pkg::sat_add32(state_next.period_bytes,
                                                           {16'd0, item.total_len});
            state_next.payload_sum    = tct_pkg::sat_add64(state_reg.payload_sum, payload);

            if (item.tcp_flags[tct_pkg::FLAG_FIN])
            begin
                if (item.src_addr == state_reg.tuple_src_addr)
                begin
                    state_next.expect_ack_dst = want;
                    state_next.fin_acked_dst  = 1'b0;
                end
                else if (item.src_addr == state_reg.tuple_dst_addr)
                begin
                    state_next.expect_ack_src = want;
                    state_next.fin_acked_src  = 1'b0;
                end
            end

            case (state_reg.lifecycle)
                tct_pkg::ST_WAIT_ACK:
                begin
                    if (item.tcp_flags[tct_pkg::FLAG_ACK])
                    begin
                        state_next.lifecycle = tct_pkg::ST_UP;
                    end
                end
                tct_pkg::ST_WAIT_SYNACK:
                begin
                    if (item.tcp_flags[tct_pkg::FLAG_SYN] && item.tcp_flags[tct_pkg::FLAG_ACK])
                    begin
                        state_next.lifecycle = tct_pkg::ST_WAIT_ACK;
                    end
                end
                tct_pkg::ST_UP:
                begin
                    if (item.tcp_flags[tct_pkg::FLAG_FIN])
                    begin
                        state_next.lifecycle = tct_pkg::ST_FIN_WAIT;
                    end
                end
                tct_pkg::ST_FIN_WAIT:
                begin
                    if (item.tcp_flags[tct_pkg::FLAG_ACK])
                    begin
                        if (item.src_addr == state_reg.tuple_src_addr)
                        begin
                            if (item.ack_number == state_next.expect_ack_src)
                            begin
                                state_next.fin_acked_src = 1'b1;
                            end
                        end
                        else if (item.src_addr == state_reg.tuple_dst_addr)
                        begin
                            if (item.ack_number == state_next.expect_ack_dst)
                            begin
                                state_next.fin_acked_dst = 1'b1;
                            end
                        end
                        if (state_next.fin_acked_src && state_next.fin_acked_dst)
                        begin
                            state_next.lifecycle = tct_pkg::ST_CLOSED;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (item.tcp_flags[tct_pkg::FLAG_RST])
            begin
                state_next.lifecycle = tct_pkg::ST_RESET;
            end
            state_next.last_seen = item.now_seconds;
        end
    end

    always_comb
    begin
        res.accepted            = acc;
        res.conn_state          = state_next.lifecycle;
        res.packet_total        = state_next.packets_seen;
        res.cur_packets         = state_next.period_packets;
        res.cur_payload_bytes   = state_next.period_payload;
        res.cur_all_bytes       = state_next.period_bytes;
        res.prev_packets        = state_next.earlier_packets;
        res.prev_payload_bytes  = state_next.earlier_payload;
        res.prev_all_bytes      = state_next.earlier_bytes;
        res.payload_grand_total = state_next.payload_sum;
        res.last_seen_seconds   = state_next.last_seen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

    a_closed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.lifecycle == tct_pkg::ST_CLOSED |=> state_reg.lifecycle == tct_pkg::ST_CLOSED)
        else $error("closed connection reopened");

    a_closed_rejects: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.lifecycle == tct_pkg::ST_CLOSED |-> !res.accepted)
        else $error("closed connection accepted a packet");

    a_empty_no_packets: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.lifecycle == tct_pkg::ST_EMPTY |-> state_reg.packets_seen == 32'd0)
        else $error("empty connection has packets");

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> state_reg.packets_seen >= $past(state_reg.packets_seen))
        else $error("packet total decreased");

    a_accept_stamps: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.accepted |->
            res.last_seen_seconds == item.now_seconds && res.packet_total != 32'd0)
        else $error("accepted packet not stamped");

endmodule

`default_nettype wire

/* rtl/tcp_connection_tracker_unit.sv */
// ----------------------------------------------------------------------------
// tcp_connection_tracker_unit
// Tracks one TCP connection from parsed headers and reports its counters.
// ----------------------------------------------------------------------------
// Two-stage pipeline: header register, then the state update into the
// result register. One header per clock is taken while res does not stall;
// each header yields exactly one result, presented on res from the result
// register once its header has moved on into a free result register.
// The rate is set by the state update loop. Backpressure on res stalls the
// input register, and hdr.ready follows res.ready combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_connection_tracker_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    tct_hdr_if.sink   hdr,
    tct_res_if.source res
);

    logic          item_valid;
    tct_pkg::hdr_t item;
    logic          advance;
    tct_pkg::res_t res_comb;
    tct_pkg::res_t res_reg;
    logic          res_valid_reg;
    logic          res_valid_next;

    assign advance = item_valid && (!res_valid_reg || res.ready);

    tct_hdr_stage u_hdr_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .hdr     (hdr),
        .advance (advance),
        .valid   (item_valid),
        .item    (item)
    );

    tct_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item),
        .res   (res_comb)
    );

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

endmodule

`default_nettype wire

/* tb/sv/tct_tracker_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tct_tracker_checker
// Watches the header and result channels of the connection tracker, predicts
// the report for every header transfer and compares each result transfer with
// the oldest predicted report, field by field.
// ----------------------------------------------------------------------------

module tct_tracker_checker (
    input  logic clk,
    input  logic rst_n,
    tct_hdr_if   hdr,
    tct_res_if   res,
    output int   mismatch_count,
    output int   reports_due
);
    import tct_pkg::*;

    conn_t conn;
    res_t  awaited_reports[$];
    res_t  oldest;

    function automatic logic [31:0] add_clamp32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void start_second(input logic [31:0] now);
        conn.earlier_packets = conn.period_packets;
        conn.earlier_payload = conn.period_payload;
        conn.earlier_bytes   = conn.period_bytes;
        conn.period_second   = now;
        conn.period_packets  = '0;
        conn.period_payload  = '0;
        conn.period_bytes    = '0;
    endfunction

    function automatic res_t track_header(input hdr_t h);
        logic [15:0] payload;
        logic [31:0] want;
        logic [64:0] sum;
        logic        fwd;
        logic        rev;
        logic        syn;
        logic        ack_f;
        logic        fin;
        logic        rst;
        res_t        r;
        syn   = h.tcp_flags[FLAG_SYN];
        ack_f = h.tcp_flags[FLAG_ACK];
        fin   = h.tcp_flags[FLAG_FIN];
        rst   = h.tcp_flags[FLAG_RST];
        payload = (h.ip_payload_len > 16'(h.tcp_header_len)) ?
                  h.ip_payload_len - 16'(h.tcp_header_len) : 16'd0;
        r = '0;
        if (h.opcode == OP_REFRESH)
        begin
            if (conn.period_second != h.now_seconds)
                start_second(h.now_seconds);
        end
        else if (conn.lifecycle == ST_EMPTY)
        begin
            // opening packet: FIN and RST are ignored, previous second is kept
            conn.tuple_src_addr = h.src_addr;
            conn.tuple_dst_addr = h.dst_addr;
            conn.tuple_src_port = h.src_port;
            conn.tuple_dst_port = h.dst_port;
            conn.lifecycle      = syn ? ST_WAIT_SYNACK : ST_UP;
            conn.packets_seen   = 32'd1;
            conn.period_second  = h.now_seconds;
            conn.period_packets = 32'd1;
            conn.period_payload = 32'(payload);
            conn.period_bytes   = 32'(h.total_len);
            conn.payload_sum    = 64'(payload);
            conn.last_seen      = h.now_seconds;
            conn.expect_ack_src = '0;
            conn.expect_ack_dst = '0;
            conn.fin_acked_src  = 1'b0;
            conn.fin_acked_dst  = 1'b0;
            r.accepted = 1'b1;
        end
        else if (conn.lifecycle != ST_CLOSED)
        begin
            fwd = h.src_addr == conn.tuple_src_addr && h.dst_addr == conn.tuple_dst_addr &&
                  h.src_port == conn.tuple_src_port && h.dst_port == conn.tuple_dst_port;
            rev = h.dst_addr == conn.tuple_src_addr && h.src_addr == conn.tuple_dst_addr &&
                  h.dst_port == conn.tuple_src_port && h.src_port == conn.tuple_dst_port;
            if (fwd || rev)
            begin
                r.accepted = 1'b1;
                conn.packets_seen = add_clamp32(conn.packets_seen, 32'd1);
                if (conn.period_second != h.now_seconds)
                    start_second(h.now_seconds);
                conn.period_packets = add_clamp32(conn.period_packets, 32'd1);
                conn.period_payload = add_clamp32(conn.period_payload, 32'(payload));
                conn.period_bytes   = add_clamp32(conn.period_bytes, 32'(h.total_len));
                sum = {1'b0, conn.payload_sum} + 65'(payload);
                conn.payload_sum = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
                if (fin)
                begin
                    want = h.seq_number + 32'(payload) + 32'd1;
                    if (h.src_addr == conn.tuple_src_addr)
                    begin
                        conn.expect_ack_dst = want;
                        conn.fin_acked_dst  = 1'b0;
                    end
                    else if (h.src_addr == conn.tuple_dst_addr)
                    begin
                        conn.expect_ack_src = want;
                        conn.fin_acked_src  = 1'b0;
                    end
                end
                case (conn.lifecycle)
                    ST_WAIT_ACK:
                        if (ack_f)
                            conn.lifecycle = ST_UP;
                    ST_WAIT_SYNACK:
                        if (syn && ack_f)
                            conn.lifecycle = ST_WAIT_ACK;
                    ST_UP:
                        if (fin)
                            conn.lifecycle = ST_FIN_WAIT;
                    ST_FIN_WAIT:
                        if (ack_f)
                        begin
                            if (h.src_addr == conn.tuple_src_addr)
                            begin
                                if (h.ack_number == conn.expect_ack_src)
                                    conn.fin_acked_src = 1'b1;
                            end
                            else if (h.src_addr == conn.tuple_dst_addr)
                            begin
                                if (h.ack_number == conn.expect_ack_dst)
                                    conn.fin_acked_dst = 1'b1;
                            end
                            if (conn.fin_acked_src && conn.fin_acked_dst)
                                conn.lifecycle = ST_CLOSED;
                        end
                    default:
                        ;
                endcase
                if (rst)
                    conn.lifecycle = ST_RESET;
                conn.last_seen = h.now_seconds;
            end
        end
        r.conn_state          = conn.lifecycle;
        r.packet_total        = conn.packets_seen;
        r.cur_packets         = conn.period_packets;
        r.cur_payload_bytes   = conn.period_payload;
        r.cur_all_bytes       = conn.period_bytes;
        r.prev_packets        = conn.earlier_packets;
        r.prev_payload_bytes  = conn.earlier_payload;
        r.prev_all_bytes      = conn.earlier_bytes;
        r.payload_grand_total = conn.payload_sum;
        r.last_seen_seconds   = conn.last_seen;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn = '0;
            awaited_reports.delete();
            mismatch_count = 0;
            reports_due = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $display("%0t: result transfer with no header pending, actual 0x%0h",
                             $time, res.data);
                    mismatch_count++;
                end
                else
                begin
                    oldest = awaited_reports.pop_front();
                    check_field("accepted", 64'(oldest.accepted), 64'(res.data.accepted));
                    check_field("conn_state", 64'(oldest.conn_state),
                                64'(res.data.conn_state));
                    check_field("packet_total", 64'(oldest.packet_total),
                                64'(res.data.packet_total));
                    check_field("cur_packets", 64'(oldest.cur_packets),
                                64'(res.data.cur_packets));
                    check_field("cur_payload_bytes", 64'(oldest.cur_payload_bytes),
                                64'(res.data.cur_payload_bytes));
                    check_field("cur_all_bytes", 64'(oldest.cur_all_bytes),
                                64'(res.data.cur_all_bytes));
                    check_field("prev_packets", 64'(oldest.prev_packets),
                                64'(res.data.prev_packets));
                    check_field("prev_payload_bytes", 64'(oldest.prev_payload_bytes),
                                64'(res.data.prev_payload_bytes));
                    check_field("prev_all_bytes", 64'(oldest.prev_all_bytes),
                                64'(res.data.prev_all_bytes));
                    check_field("payload_grand_total", oldest.payload_grand_total,
                                res.data.payload_grand_total);
                    check_field("last_seen_seconds", 64'(oldest.last_seen_seconds),
                                64'(res.data.last_seen_seconds));
                end
            end
            if (hdr.valid && hdr.ready)
                awaited_reports.push_back(track_header(hdr.data));
            reports_due = awaited_reports.size();
        end
    end

endmodule

/* tb/sv/tb_tcp_connection_tracker_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tcp_connection_tracker_unit
// Drives parsed headers into the connection tracker: a short directed opening
// and handshake, then random traffic on the tracked tuple mixed with near-miss
// headers and period refreshes, ending in either a full close or an RST.
// Sender and receiver idle at random; a checker beside the block scores it.
// ----------------------------------------------------------------------------

module tb_tcp_connection_tracker_unit;
    import tct_pkg::*;

    localparam int RANDOM_ITEMS = 1900;
    localparam int CLOSED_TAIL  = 40;
    localparam int RESET_TAIL   = 80;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    int          mismatch_count;
    int          reports_due;
    int          send_idle_pct = 8;
    int          stall_pct = 70;
    logic [31:0] conn_src_addr;
    logic [31:0] conn_dst_addr;
    logic [15:0] conn_src_port;
    logic [15:0] conn_dst_port;
    logic [31:0] now_cursor;
    logic [31:0] ack_for_src;
    logic [31:0] ack_for_dst;
    bit          same_addr;
    bit          close_end;

    tct_hdr_if hdr_ch();
    tct_res_if res_ch();

    tcp_connection_tracker_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hdr   (hdr_ch),
        .res   (res_ch)
    );

    tct_tracker_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .hdr            (hdr_ch),
        .res            (res_ch),
        .mismatch_count (mismatch_count),
        .reports_due    (reports_due)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
        res_ch.ready <= ($urandom_range(99) >= stall_pct);

    initial
    begin
        #2_000_000;
        $display("tcp_connection_tracker_unit: mismatch");
        $finish;
    end

    function automatic hdr_t conn_hdr(input bit from_dst);
        hdr_t h;
        h.opcode         = OP_PACKET;
        h.now_seconds    = now_cursor;
        h.src_addr       = from_dst ? conn_dst_addr : conn_src_addr;
        h.dst_addr       = from_dst ? conn_src_addr : conn_dst_addr;
        h.src_port       = from_dst ? conn_dst_port : conn_src_port;
        h.dst_port       = from_dst ? conn_src_port : conn_dst_port;
        h.tcp_flags      = '0;
        h.tcp_flags[FLAG_ACK] = 1'b1;
        h.seq_number     = $urandom;
        h.ack_number     = $urandom;
        case ($urandom_range(9))
            0:       h.ip_payload_len = 16'($urandom);
            1, 2:    h.ip_payload_len = 16'($urandom_range(80));
            default: h.ip_payload_len = 16'($urandom_range(1500));
        endcase
        h.tcp_header_len = 6'($urandom_range(60));
        h.total_len      = ($urandom_range(3) == 0) ? 16'($urandom) : h.ip_payload_len + 16'd20;
        return h;
    endfunction

    function automatic hdr_t noise_hdr();
        hdr_t h;
        h = conn_hdr(1'($urandom_range(1)));
        h.tcp_flags = 4'($urandom);
        case ($urandom_range(4))
            0:
            begin
                h.src_addr = $urandom;
                h.dst_addr = $urandom;
                h.src_port = 16'($urandom);
                h.dst_port = 16'($urandom);
            end
            1:       h.src_addr ^= 32'd1 << $urandom_range(31);
            2:       h.dst_addr ^= 32'd1 << $urandom_range(31);
            3:       h.src_port ^= 16'd1 << $urandom_range(15);
            default: h.dst_port ^= 16'd1 << $urandom_range(15);
        endcase
        return h;
    endfunction

    function automatic hdr_t refresh_hdr(input logic [31:0] now);
        hdr_t h;
        h = noise_hdr();
        h.opcode = OP_REFRESH;
        h.now_seconds = now;
        return h;
    endfunction

    task automatic send_hdr(input hdr_t h);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            hdr_ch.valid <= 1'b0;
            @(negedge clk);
        end
        hdr_ch.valid <= 1'b1;
        hdr_ch.data  <= h;
        do
            @(posedge clk);
        while (!hdr_ch.ready);
    endtask

    // keeps the ACK number each side needs to acknowledge the other's FIN
    task automatic send_conn(input hdr_t h);
        logic [15:0] payload;
        logic [31:0] want;
        payload = (h.ip_payload_len > 16'(h.tcp_header_len)) ?
                  h.ip_payload_len - 16'(h.tcp_header_len) : 16'd0;
        if (h.tcp_flags[FLAG_FIN])
        begin
            want = h.seq_number + 32'(payload) + 32'd1;
            if (h.src_addr == conn_src_addr)
                ack_for_dst = want;
            else
                ack_for_src = want;
        end
        send_hdr(h);
    endtask

    // dst-side ACKs never match in the main traffic, so the close is held for the end
    task automatic send_mixed(input bit allow_rst);
        hdr_t        h;
        int unsigned roll;
        if ($urandom_range(9) == 0)
            now_cursor++;
        if ($urandom_range(249) == 0)
            now_cursor = $urandom;
        roll = $urandom_range(99);
        if (roll < 6)
            send_hdr(refresh_hdr(($urandom_range(7) == 0) ? 32'($urandom) :
                                 now_cursor + 32'($urandom_range(1))));
        else if (roll < 20)
            send_hdr(noise_hdr());
        else
        begin
            h = conn_hdr(1'($urandom_range(1)));
            if (allow_rst)
                h.tcp_flags = 4'($urandom);
            else
            begin
                h.tcp_flags[FLAG_SYN] = ($urandom_range(3) == 0);
                h.tcp_flags[FLAG_ACK] = ($urandom_range(3) != 0);
                h.tcp_flags[FLAG_FIN] = ($urandom_range(5) == 0);
            end
            if (h.src_addr == conn_src_addr)
            begin
                if ($urandom_range(3) == 0)
                    h.ack_number = ack_for_src;
            end
            else if (h.ack_number == ack_for_dst)
                h.ack_number = ~h.ack_number;
            send_conn(h);
        end
    endtask

    initial
    begin
        hdr_t h;
        int   waited;
        hdr_ch.valid = 1'b0;
        hdr_ch.data  = '0;
        res_ch.ready = 1'b0;
        same_addr     = ($urandom_range(3) == 0);
        conn_src_addr = $urandom;
        conn_dst_addr = same_addr ? conn_src_addr : conn_src_addr ^ (32'd1 << $urandom_range(31));
        conn_src_port = 16'($urandom);
        conn_dst_port = conn_src_port ^ (16'd1 << $urandom_range(15));
        close_end     = !same_addr && ($urandom_range(1) == 1);
        ack_for_src   = '0;
        ack_for_dst   = '0;
        now_cursor    = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // refresh while empty, with and without a second change
        send_hdr(refresh_hdr(32'd0));
        send_hdr(refresh_hdr(32'd5));

        // opening packet carries FIN and RST, which must be ignored
        now_cursor = 32'd10;
        h = conn_hdr(1'b0);
        h.tcp_flags = '1;
        h.tcp_flags[FLAG_SYN] = ($urandom_range(3) != 0);
        h.ip_payload_len = 16'd100;
        h.tcp_header_len = 6'd20;
        h.total_len = 16'd140;
        send_hdr(h);

        h = conn_hdr(1'b0);
        h.src_port ^= 16'h0001;
        send_hdr(h);
        h = conn_hdr(1'b1);
        h.dst_addr ^= 32'h8000_0000;
        send_hdr(h);

        h = conn_hdr(1'b1);
        h.tcp_flags[FLAG_SYN] = 1'b1;
        h.ip_payload_len = 16'(h.tcp_header_len);
        send_conn(h);

        // payload underflow clamps to zero
        h = conn_hdr(1'b0);
        h.ip_payload_len = 16'd10;
        h.tcp_header_len = 6'd60;
        send_conn(h);

        h = conn_hdr(1'b0);
        h.ip_payload_len = 16'hFFFF;
        h.tcp_header_len = 6'd0;
        h.total_len = 16'hFFFF;
        h.seq_number = 32'hFFFF_FFFF;
        h.ack_number = 32'hFFFF_FFFF;
        send_conn(h);

        now_cursor = 32'd11;
        send_conn(conn_hdr(1'b1));
        send_hdr(refresh_hdr(32'd11));
        send_hdr(refresh_hdr(32'd12));

        now_cursor = 32'hFFFF_FFFF;
        h = conn_hdr(1'b0);
        h.tcp_header_len = 6'd60;
        h.ip_payload_len = 16'd60;
        h.total_len = 16'd0;
        h.seq_number = 32'd0;
        h.ack_number = 32'd0;
        send_conn(h);

        now_cursor = 32'd0;
        h = conn_hdr(1'b1);
        h.ip_payload_len = 16'd0;
        h.tcp_header_len = 6'd20;
        send_conn(h);

        h = '1;
        h.opcode = OP_PACKET;
        h.tcp_header_len = 6'd60;
        send_hdr(h);
        h = '1;
        h.tcp_header_len = 6'd60;
        send_hdr(h);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 70;
                stall_pct = 8;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            send_mixed(1'b0);
        end

        if (close_end)
        begin
            h = conn_hdr(1'b0);
            h.tcp_flags[FLAG_FIN] = 1'b1;
            send_conn(h);
            h = conn_hdr(1'b1);
            h.tcp_flags[FLAG_FIN] = 1'b1;
            h.ack_number = ack_for_dst;
            send_conn(h);
            h = conn_hdr(1'b0);
            h.ack_number = ack_for_src;
            send_conn(h);
            repeat (CLOSED_TAIL) send_mixed(1'b1);
        end
        else
        begin
            h = conn_hdr(1'($urandom_range(1)));
            h.tcp_flags[FLAG_RST] = 1'b1;
            send_conn(h);
            repeat (RESET_TAIL) send_mixed(1'b1);
        end

        @(negedge clk);
        hdr_ch.valid <= 1'b0;
        waited = 0;
        while (reports_due != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (reports_due != 0)
            $display("%0t: %0d results never arrived", $time, reports_due);
        if (mismatch_count == 0 && reports_due == 0)
            $display("tcp_connection_tracker_unit: match");
        else
            $display("tcp_connection_tracker_unit: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tct_pkg.sv
rtl/tct_hdr_if.sv
rtl/tct_res_if.sv
rtl/tct_hdr_stage.sv
rtl/tct_core.sv
rtl/tcp_connection_tracker_unit.sv
tb/sv/tct_tracker_checker.sv
tb/sv/tb_tcp_connection_tracker_unit.sv
